/* design/x86d_pkg.sv */
// ----------------------------------------------------------------------------
// x86d_pkg
// Types, codes and decode functions shared by the instruction decoder.
// ----------------------------------------------------------------------------
package x86d_pkg;

    localparam logic [2:0] GRP_RMREG     = 3'd0;
    localparam logic [2:0] GRP_IMM_MOV   = 3'd1;
    localparam logic [2:0] GRP_IMM_ARITH = 3'd2;
    localparam logic [2:0] GRP_IMM_REG   = 3'd3;
    localparam logic [2:0] GRP_ACC       = 3'd4;
    localparam logic [2:0] GRP_NONE      = 3'd5;

    localparam logic [2:0] KIND_MOV  = 3'd0;
    localparam logic [2:0] KIND_ADD  = 3'd1;
    localparam logic [2:0] KIND_SUB  = 3'd2;
    localparam logic [2:0] KIND_CMP  = 3'd3;
    localparam logic [2:0] KIND_RAW1 = 3'd4;
    localparam logic [2:0] KIND_RAW2 = 3'd5;

    localparam logic [1:0] FORM_RMREG   = 2'd0;
    localparam logic [1:0] FORM_IMM_RM  = 2'd1;
    localparam logic [1:0] FORM_IMM_REG = 2'd2;
    localparam logic [1:0] FORM_ACC     = 2'd3;

    localparam logic [5:0] OP6_MOV_RM   = 6'b100010;
    localparam logic [5:0] OP6_ADD_RM   = 6'b000000;
    localparam logic [5:0] OP6_SUB_RM   = 6'b001010;
    localparam logic [5:0] OP6_CMP_RM   = 6'b001110;
    localparam logic [6:0] OP7_MOV_IMM  = 7'b1100011;
    localparam logic [5:0] OP6_ARITH_IM = 6'b100000;
    localparam logic [3:0] OP4_MOV_REG  = 4'b1011;
    localparam logic [5:0] OP6_ACC      = 6'b101000;

    localparam logic [2:0] EXT_ADD = 3'b000;
    localparam logic [2:0] EXT_SUB = 3'b101;
    localparam logic [2:0] EXT_CMP = 3'b111;
    localparam logic [2:0] RM_DIRECT = 3'b110;

    typedef struct packed {
        logic [7:0] code_byte;
        logic [2:0] grp;
    } queue_entry_t;

    // last field in the lowest bits
    typedef struct packed {
        logic [7:0]  raw_second;
        logic [7:0]  raw_first;
        logic [15:0] immediate;
        logic [15:0] disp_or_addr;
        logic [2:0]  rm_num;
        logic [1:0]  mode;
        logic [2:0]  reg_num;
        logic        data_wide;
        logic        wide;
        logic        reg_is_dest;
        logic [1:0]  form;
        logic [2:0]  op_kind;
    } result_t;

    function automatic logic [2:0] group_of(input logic [7:0] op);
        logic [2:0] g;
        g = GRP_NONE;
        if (op[7:2] == OP6_MOV_RM || op[7:2] == OP6_ADD_RM ||
            op[7:2] == OP6_SUB_RM || op[7:2] == OP6_CMP_RM) begin
            g = GRP_RMREG;
        end else if (op[7:1] == OP7_MOV_IMM) begin
            g = GRP_IMM_MOV;
        end else if (op[7:2] == OP6_ARITH_IM) begin
            g = GRP_IMM_ARITH;
        end else if (op[7:4] == OP4_MOV_REG) begin
            g = GRP_IMM_REG;
        end else if (op[7:2] == OP6_ACC) begin
            g = GRP_ACC;
        end
        return g;
    endfunction

    function automatic logic [2:0] kind_of(input logic [2:0] grp, input logic [7:0] op,
                                           input logic [7:0] m);
        logic [2:0] k;
        k = KIND_MOV;
        case (grp)
            GRP_RMREG: begin
                if (op[7:2] == OP6_MOV_RM) k = KIND_MOV;
                else if (op[7:2] == OP6_ADD_RM) k = KIND_ADD;
                else if (op[7:2] == OP6_SUB_RM) k = KIND_SUB;
                else k = KIND_CMP;
            end
            GRP_IMM_MOV: begin
                k = (m[5:3] == EXT_ADD) ? KIND_MOV : KIND_RAW2;
            end
            GRP_IMM_ARITH: begin
                if (m[5:3] == EXT_ADD) k = KIND_ADD;
                else if (m[5:3] == EXT_SUB) k = KIND_SUB;
                else if (m[5:3] == EXT_CMP) k = KIND_CMP;
                else k = KIND_RAW2;
            end
            default: k = KIND_MOV;
        endcase
        return k;
    endfunction

    function automatic logic data_wide_of(input logic [2:0] grp, input logic [7:0] op);
        logic dw;
        case (grp)
            GRP_IMM_MOV:   dw = op[0];
            GRP_IMM_ARITH: dw = (op[1:0] == 2'b01);
            GRP_IMM_REG:   dw = op[3];
            default:       dw = 1'b0;
        endcase
        return dw;
    endfunction

    function automatic logic [1:0] disp_len(input logic [7:0] m);
        logic [1:0] n;
        case (m[7:6])
            2'd1:    n = 2'd1;
            2'd2:    n = 2'd2;
            2'd3:    n = 2'd0;
            default: n = (m[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [15:0] sext8(input logic [7:0] b);
        return {{8{b[7]}}, b};
    endfunction

    function automatic result_t make_result(input logic [2:0] grp, input logic [7:0] op,
                                            input logic [7:0] m, input logic [15:0] disp,
                                            input logic [15:0] imm);
        result_t r;
        r = '0;
        case (grp)
            GRP_RMREG, GRP_IMM_MOV, GRP_IMM_ARITH: begin
                r.op_kind      = kind_of(grp, op, m);
                r.form         = (grp == GRP_RMREG) ? FORM_RMREG : FORM_IMM_RM;
                r.reg_is_dest  = (grp == GRP_RMREG) ? op[1] : 1'b0;
                r.wide         = op[0];
                r.data_wide    = (grp == GRP_RMREG) ? 1'b0 : data_wide_of(grp, op);
                r.reg_num      = m[5:3];
                r.mode         = m[7:6];
                r.rm_num       = m[2:0];
                r.disp_or_addr = disp;
                r.immediate    = (grp == GRP_RMREG) ? 16'd0 : imm;
            end
            GRP_IMM_REG: begin
                r.op_kind     = KIND_MOV;
                r.form        = FORM_IMM_REG;
                r.reg_is_dest = 1'b1;
                r.wide        = op[3];
                r.data_wide   = op[3];
                r.reg_num     = op[2:0];
                r.immediate   = imm;
            end
            GRP_ACC: begin
                r.op_kind      = KIND_MOV;
                r.form         = FORM_ACC;
                r.reg_is_dest  = ~op[1];
                r.wide         = op[0];
                r.disp_or_addr = disp;
            end
            default: begin
                r.op_kind   = KIND_RAW1;
                r.raw_first = op;
            end
        endcase
        return r;
    endfunction

endpackage

/* design/x86d_front.sv */
// ----------------------------------------------------------------------------
// x86d_front
// Input side: accept code bytes and tag each with its opcode group.
// ----------------------------------------------------------------------------
module x86d_front
    import x86d_pkg::*;
(
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         queue_full,
    output logic         push,
    output queue_entry_t push_entry
);

    assign s_tready             = ~queue_full;
    assign push                 = s_tvalid & ~queue_full;
    assign push_entry.code_byte = s_tdata;
    assign push_entry.grp       = group_of(s_tdata);

endmodule

/* design/x86d_queue.sv */
// ----------------------------------------------------------------------------
// x86d_queue
// Small first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module x86d_queue
    import x86d_pkg::*;
#(
    parameter int DEPTH = 4
)(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  queue_entry_t push_entry,
    output logic         full,
    input  logic         pop,
    output logic         head_valid,
    output queue_entry_t head_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    queue_entry_t       entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entry_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* design/x86d_back.sv */
// ----------------------------------------------------------------------------
// x86d_back
// Decode side: step the instruction phase machine and hold the result.
// ----------------------------------------------------------------------------
module x86d_back
    import x86d_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         head_valid,
    input  queue_entry_t head_entry,
    output logic         pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata
);

    localparam logic [2:0] PH_OPCODE    = 3'd0;
    localparam logic [2:0] PH_MODRM     = 3'd1;
    localparam logic [2:0] PH_DISP_LO   = 3'd2;
    localparam logic [2:0] PH_DISP_HI   = 3'd3;
    localparam logic [2:0] PH_DATA_LO   = 3'd4;
    localparam logic [2:0] PH_DATA_HI   = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [2:0]  grp_reg, grp_next;
    logic [7:0]  modrm_reg, modrm_next;
    logic [15:0] disp_reg, disp_next;
    logic [7:0]  data_low_reg, data_low_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_data_reg, out_data_next;

    logic        emit;
    result_t     emit_data;
    logic [7:0]  b;
    logic [15:0] disp_full;

    assign pop      = head_valid & (~out_valid_reg | m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign b        = head_entry.code_byte;
    assign disp_full = {b, disp_reg[7:0]};

    always_comb begin
        phase_next    = phase_reg;
        opcode_next   = opcode_reg;
        grp_next      = grp_reg;
        modrm_next    = modrm_reg;
        disp_next     = disp_reg;
        data_low_next = data_low_reg;
        emit          = 1'b0;
        emit_data     = '0;
        case (phase_reg)
            PH_MODRM: begin
                modrm_next = b;
                if (kind_of(grp_reg, opcode_reg, b) == KIND_RAW2) begin
                    emit                 = 1'b1;
                    emit_data.op_kind    = KIND_RAW2;
                    emit_data.raw_first  = opcode_reg;
                    emit_data.raw_second = b;
                    phase_next           = PH_OPCODE;
                end else if (disp_len(b) != 2'd0) begin
                    phase_next = PH_DISP_LO;
                end else if (grp_reg == GRP_RMREG) begin
                    emit       = 1'b1;
                    emit_data  = make_result(grp_reg, opcode_reg, b, disp_reg, 16'd0);
                    phase_next = PH_OPCODE;
                end else begin
                    phase_next = PH_DATA_LO;
                end
            end
            PH_DISP_LO: begin
                if (grp_reg != GRP_ACC && disp_len(modrm_reg) == 2'd1) begin
                    disp_next = sext8(b);
                    if (grp_reg == GRP_RMREG) begin
                        emit       = 1'b1;
                        emit_data  = make_result(grp_reg, opcode_reg, modrm_reg,
                                                 sext8(b), 16'd0);
                        phase_next = PH_OPCODE;
                    end else begin
                        phase_next = PH_DATA_LO;
                    end
                end else begin
                    disp_next  = {8'd0, b};
                    phase_next = PH_DISP_HI;
                end
            end
            PH_DISP_HI: begin
                disp_next = disp_full;
                if (grp_reg == GRP_ACC || grp_reg == GRP_RMREG) begin
                    emit       = 1'b1;
                    emit_data  = make_result(grp_reg, opcode_reg, modrm_reg, disp_full, 16'd0);
                    phase_next = PH_OPCODE;
                end else begin
                    phase_next = PH_DATA_LO;
                end
            end
            PH_DATA_LO: begin
                if (data_wide_of(grp_reg, opcode_reg)) begin
                    data_low_next = b;
                    phase_next    = PH_DATA_HI;
                end else begin
                    emit       = 1'b1;
                    emit_data  = make_result(grp_reg, opcode_reg, modrm_reg, disp_reg, sext8(b));
                    phase_next = PH_OPCODE;
                end
            end
            PH_DATA_HI: begin
                emit       = 1'b1;
                emit_data  = make_result(grp_reg, opcode_reg, modrm_reg, disp_reg,
                                         {b, data_low_reg});
                phase_next = PH_OPCODE;
            end
            default: begin
                opcode_next   = b;
                grp_next      = head_entry.grp;
                modrm_next    = '0;
                disp_next     = '0;
                data_low_next = '0;
                case (head_entry.grp)
                    GRP_RMREG, GRP_IMM_MOV, GRP_IMM_ARITH: phase_next = PH_MODRM;
                    GRP_IMM_REG:                           phase_next = PH_DATA_LO;
                    GRP_ACC:                               phase_next = PH_DISP_LO;
                    default: begin
                        emit       = 1'b1;
                        emit_data  = make_result(GRP_NONE, b, 8'd0, 16'd0, 16'd0);
                        phase_next = PH_OPCODE;
                    end
                endcase
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (pop && emit) begin
            out_valid_next = 1'b1;
            out_data_next  = emit_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_OPCODE;
            opcode_reg    <= '0;
            grp_reg       <= GRP_RMREG;
            modrm_reg     <= '0;
            disp_reg      <= '0;
            data_low_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg    <= phase_next;
                opcode_reg   <= opcode_next;
                grp_reg      <= grp_next;
                modrm_reg    <= modrm_next;
                disp_reg     <= disp_next;
                data_low_reg <= data_low_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

endmodule

/* design/x86_16bit_instruction_decoder_core.sv */
// ----------------------------------------------------------------------------
// x86_16bit_instruction_decoder_core
// Byte-serial decoder for mov/add/sub/cmp of the 16-bit x86 instruction set.
// ----------------------------------------------------------------------------
// The core takes one instruction byte per cycle on the s_ channel while s_tready
// is high and, after the last byte of each instruction, delivers one 64-bit decoded
// record on the m_ channel; unrecognized opcodes and opcode-extension pairs come
// out as raw records. Sustained throughput is one byte per cycle while the m_
// channel does not stall, set by the single-step phase machine in the decode stage.
// An accepted byte is queued before the decode stage sees it, and its record is
// registered before it appears on m_tdata. A QUEUE_DEPTH-entry byte queue lets
// input and output stall independently; s_tready drops only when that queue is full.
module x86_16bit_instruction_decoder_core
    import x86d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] code_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] op_kind, [4:3] form, [5] reg_is_dest, [6] wide, [7] data_wide,
    // [10:8] reg_num, [12:11] mode, [15:13] rm_num, [31:16] disp_or_addr,
    // [47:32] immediate, [55:48] raw_first, [63:56] raw_second
    output logic [63:0] m_tdata
);

    logic         queue_full;
    logic         push;
    queue_entry_t push_entry;
    logic         pop;
    logic         head_valid;
    queue_entry_t head_entry;

    x86d_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    x86d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    x86d_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
